// ----- hw/rtl/rhc_pkg.sv -----
package rhc_pkg;

    localparam int ChanW = 8;
    localparam int HueW  = 11;
    localparam int QW    = 9;
    localparam int DivStages = QW;

    typedef logic [ChanW-1:0] t_chan;
    typedef logic [HueW-1:0]  t_hue;

    typedef enum logic [1:0] {
        FUNC_RGB2HSV = 2'd0,
        FUNC_HSV2RGB = 2'd1
    } t_func_code;

    typedef struct packed {
        logic          vld;
        logic          func;
        logic          grey;
        logic          neg;
        logic [HueW-1:0] base;
        t_chan         val;
        t_chan         delta;
        logic [16:0]   srem;
        logic [ChanW-1:0] sq;
        logic [16:0]   hrem;
        logic [QW-1:0] hq;
        t_chan         r_o;
        t_chan         g_o;
        t_chan         b_o;
    } t_lane;

endpackage

// ----- hw/rtl/rgb_hsv_converter.sv -----
// Pixel color converter between RGB and HSV, one request per clock.
// Drive the fields with i_func and pulse start; a request is taken
// whenever start is high and busy is low. busy is always low, so a new
// request may follow in every cycle.
// i_func low converts RGB to HSV, high converts HSV to RGB; the unused
// result fields read as zero.
// Each result passes the front register, the division cells and the output
// register and is shown for one cycle, marked by o_done. Results leave in request order.
// The division chain has one cell per quotient bit of the
// hue quotient, shared with the saturation quotient.
// Throughput is one result per clock.
// Synchronous reset clears all valid bits; no request in flight survives.
// The receiver cannot stall; o_done results must be taken as they come.
module rgb_hsv_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_func,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    input  logic [10:0]           i_in_hue,
    input  logic [7:0]            i_in_sat,
    input  logic [7:0]            i_in_val,
    output logic                  o_done,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [10:0]           o_out_hue,
    output logic [7:0]            o_out_sat,
    output logic [7:0]            o_out_val
);
    import rhc_pkg::*;

    t_lane lanes [DivStages+1];
    logic r_done;
    t_chan r_red, r_green, r_blue, r_sat, r_val;
    t_hue r_hue;
    logic [HueW:0] h;
    t_lane t;

    assign busy = 1'b0;

    rhc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start & ~busy), .i_func(i_func),
        .i_red(i_in_red), .i_green(i_in_green), .i_blue(i_in_blue),
        .i_hue(i_in_hue), .i_sat(i_in_sat), .i_val(i_in_val), .o_lane(lanes[0])
    );

    for (genvar gi = 0; gi < DivStages; gi++) begin : g_cell
        rhc_cell #(.Step(gi)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lane(lanes[gi]), .o_lane(lanes[gi+1])
        );
    end

    always_comb begin
        t = lanes[DivStages];
        if (t.neg) begin
            h = (HueW+1)'(t.base) - (HueW+1)'(t.hq) - (HueW+1)'(t.hrem != '0);
        end else begin
            h = (HueW+1)'(t.base) + (HueW+1)'(t.hq);
        end
        if (h[HueW]) h = h + (HueW+1)'(1536);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= t.vld;
        end
        if (t.func == FUNC_HSV2RGB[0]) begin
            r_red <= t.r_o; r_green <= t.g_o; r_blue <= t.b_o;
            r_hue <= '0; r_sat <= '0; r_val <= '0;
        end else begin
            r_red <= '0; r_green <= '0; r_blue <= '0;
            r_val <= t.val;
            r_hue <= t.grey ? '0 : h[HueW-1:0];
            r_sat <= t.grey ? '0 : t.sq;
        end
    end

    assign o_done      = r_done;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
    assign o_out_hue   = r_hue;
    assign o_out_sat   = r_sat;
    assign o_out_val   = r_val;

`ifndef SYNTHESIS
    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy asserted");
    a_done_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_out_hue < 11'd1536)
        else $error("hue out of range");
`endif
endmodule

// ----- hw/rtl/rhc_front.sv -----
module rhc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic             i_func,
    input  rhc_pkg::t_chan   i_red,
    input  rhc_pkg::t_chan   i_green,
    input  rhc_pkg::t_chan   i_blue,
    input  rhc_pkg::t_hue    i_hue,
    input  rhc_pkg::t_chan   i_sat,
    input  rhc_pkg::t_chan   i_val,
    output rhc_pkg::t_lane   o_lane
);
    import rhc_pkg::*;

    t_chan r_v, r_s, r_red, r_green, r_blue;
    logic [2:0] r_sec;
    logic r_vld, r_func;
    logic [15:0] r_vs, r_vsf, r_vsn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_func  <= i_func;
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_v     <= i_val;
        r_s     <= i_sat;
        r_sec   <= i_hue[10:8];
        r_vs    <= 16'(i_sat) * 16'(i_hue[7:0]);
        r_vsn   <= 16'(i_sat) * (16'd256 - 16'(i_hue[7:0]));
        r_vsf   <= 16'(i_val) * (16'd255 - 16'(i_sat));
    end

    t_chan mx, mn, dl, l, m, n, ro, go, bo;
    logic [23:0] pm, pn;
    logic signed [9:0] diff;
    logic [HueW-1:0] base;

    always_comb begin
        mx = r_red;
        if (r_green > mx) mx = r_green;
        if (r_blue > mx) mx = r_blue;
        mn = r_red;
        if (r_green < mn) mn = r_green;
        if (r_blue < mn) mn = r_blue;
        dl = mx - mn;
        if (mx == r_red) begin
            base = '0;
            diff = 10'(r_green) - 10'(r_blue);
        end else if (mx == r_green) begin
            base = HueW'(512);
            diff = 10'(r_blue) - 10'(r_red);
        end else begin
            base = HueW'(1024);
            diff = 10'(r_red) - 10'(r_green);
        end
        // Division by 255 is exact as (y + (y >> 8) + 1) >> 8 for these ranges.
        l  = ChanW'((17'(r_vsf) + 17'(r_vsf[15:8]) + 17'd1) >> 8);
        pm = 24'(r_v) * (24'd65280 - 24'(r_vs));
        pn = 24'(r_v) * (24'd65280 - 24'(r_vsn));
        m  = ChanW'((17'(pm[23:8]) + 17'(pm[23:16]) + 17'd1) >> 8);
        n  = ChanW'((17'(pn[23:8]) + 17'(pn[23:16]) + 17'd1) >> 8);
        if (r_s == '0) begin
            ro = r_v; go = r_v; bo = r_v;
        end else begin
            case (r_sec)
                3'd0: begin ro = r_v; go = n;   bo = l;   end
                3'd1: begin ro = m;   go = r_v; bo = l;   end
                3'd2: begin ro = l;   go = r_v; bo = n;   end
                3'd3: begin ro = l;   go = m;   bo = r_v; end
                3'd4: begin ro = n;   go = l;   bo = r_v; end
                default: begin ro = r_v; go = l; bo = m; end
            endcase
        end
        o_lane       = '0;
        o_lane.vld   = r_vld;
        o_lane.func  = r_func;
        o_lane.grey  = (dl == '0);
        o_lane.neg   = diff[9];
        o_lane.base  = base;
        o_lane.val   = mx;
        o_lane.delta = dl;
        o_lane.srem  = 17'(16'd255 * 16'(dl));
        o_lane.hrem  = 17'({diff[9] ? 8'(-diff) : 8'(diff), 8'd0});
        o_lane.r_o   = ro;
        o_lane.g_o   = go;
        o_lane.b_o   = bo;
    end
endmodule

// ----- hw/rtl/rhc_cell.sv -----
module rhc_cell #(
    parameter int Step = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rhc_pkg::t_lane i_lane,
    output rhc_pkg::t_lane o_lane
);
    import rhc_pkg::*;

    t_lane n_lane, r_lane;
    logic [16:0] sd, hd;
    localparam int Sh = DivStages - 1 - Step;

    always_comb begin
        n_lane = i_lane;
        sd = 17'(i_lane.val) << Sh;
        hd = 17'(i_lane.delta) << Sh;
        if (Sh < ChanW) begin
            if (i_lane.val != '0 && i_lane.srem >= sd) begin
                n_lane.srem = i_lane.srem - sd;
                n_lane.sq[Sh % ChanW] = 1'b1;
            end
        end
        if (i_lane.delta != '0 && i_lane.hrem >= hd) begin
            n_lane.hrem = i_lane.hrem - hd;
            n_lane.hq[Sh] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
